@@ sv/d8ot_pkg.sv @@
// Package for the dual 8-bit overflow timer.
// Holds the command codes, register indexes, offsets and the result word type.
// No dependencies; every other file of the block imports it.
package d8ot_pkg;

	// Command codes carried in the mode field.
	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2
	} mode_e_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_TICK_DIVISOR = 1'b0,
		REG_IRQ_ENABLE   = 1'b1
	} cfg_reg_t;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned DIV_W      = 16;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned OFS_W      = 4;

	// Register offsets from the timer base.
	localparam logic [OFS_W-1:0] OFS_STATUS = 4'd2;
	localparam logic [OFS_W-1:0] OFS_COUNT  = 4'd8;

	// Overflow bit position in the status register.
	localparam int unsigned OVF_BIT = 5;

	localparam logic [DIV_W-1:0]  DIV_RESET = 16'd1024;
	localparam logic [BYTE_W-1:0] COUNT_MAX = 8'hFF;

	// One result word.
	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              handled;
		logic              irq_request;
	} rsp_t;

endpackage

@@ sv/d8ot_ifs.sv @@
// Handshake interfaces for the command and response channels of the timer.
// Depends on d8ot_pkg for the field widths.
interface d8ot_cmd_if
	import d8ot_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic [OFS_W-1:0]  reg_offset;
	logic [BYTE_W-1:0] write_data;
	logic              interrupts_masked;

	modport source (output valid, mode, reg_offset, write_data, interrupts_masked,
		input ready);
	modport sink (input valid, mode, reg_offset, write_data, interrupts_masked,
		output ready);
endinterface

interface d8ot_rsp_if
	import d8ot_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_data;
	logic              handled;
	logic              irq_request;

	modport source (output valid, read_data, handled, irq_request, input ready);
	modport sink (input valid, read_data, handled, irq_request, output ready);
endinterface

@@ sv/dual_8bit_overflow_timer.sv @@
// Dual 8-bit overflow timer: every command word (tick, register read or register write) is
// taken and updates the timer state at once, so one word can be accepted on every clock. Each
// word yields one result word, held in a two-entry output buffer; the command channel stalls
// only while both entries are full. Depends on d8ot_pkg and d8ot_ifs.
module dual_8bit_overflow_timer
	import d8ot_pkg::*;
#(
	parameter int CHANNELS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	d8ot_cmd_if.sink              cmd,
	d8ot_rsp_if.source            rsp
);

	logic accept;
	logic buf_ready;
	rsp_t core_result;
	rsp_t out_word;

	assign cmd.ready = buf_ready;
	assign accept    = cmd.valid && buf_ready;

	// Timer state and per-word update.
	d8ot_core #(
		.CHANNELS(CHANNELS)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.accept            (accept),
		.mode              (cmd.mode),
		.reg_offset        (cmd.reg_offset),
		.write_data        (cmd.write_data),
		.interrupts_masked (cmd.interrupts_masked),
		.result            (core_result)
	);

	// Result buffering toward the response channel.
	d8ot_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (buf_ready),
		.in_data   (core_result),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (out_word)
	);

	assign rsp.read_data   = out_word.read_data;
	assign rsp.handled     = out_word.handled;
	assign rsp.irq_request = out_word.irq_request;

endmodule

@@ sv/d8ot_core.sv @@
// Timer state and the single-pass update for one command word.
// Depends on d8ot_pkg; state advances on each accepted word, result is combinational.
module d8ot_core
	import d8ot_pkg::*;
#(
	parameter int CHANNELS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic [1:0]            mode,
	input  logic [OFS_W-1:0]      reg_offset,
	input  logic [BYTE_W-1:0]     write_data,
	input  logic                  interrupts_masked,
	output rsp_t                  result
);

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Configuration registers.
	logic [DIV_W-1:0] tick_divisor_q;
	logic             irq_enable_q;

	// Per-channel state.
	logic [BYTE_W-1:0] count_q [CHANNELS];
	logic              ovf_q   [CHANNELS];
	logic [DIV_W-1:0]  phase_q [CHANNELS];
	logic [BYTE_W-1:0] status_q[CHANNELS];
	logic              armed_q;

	logic [BYTE_W-1:0] count_d [CHANNELS];
	logic              ovf_d   [CHANNELS];
	logic [DIV_W-1:0]  phase_d [CHANNELS];
	logic [BYTE_W-1:0] status_d[CHANNELS];
	logic              armed_d;

	logic [DIV_W-1:0] div_eff;
	logic [OFS_W-1:0] st_rel, cnt_rel;
	logic             st_hit, cnt_hit;
	logic [CW-1:0]    st_ch, cnt_ch;
	logic [DIV_W:0]   phase_inc [CHANNELS];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_divisor_q <= DIV_RESET;
			irq_enable_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TICK_DIVISOR: tick_divisor_q <= cfg_data[DIV_W-1:0];
				REG_IRQ_ENABLE:   irq_enable_q   <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// A zero divisor steps on every tick.
	assign div_eff = (tick_divisor_q == '0) ? DIV_W'(1) : tick_divisor_q;

	// Offset decode for the status and counter register pairs.
	assign st_rel  = reg_offset - OFS_STATUS;
	assign cnt_rel = reg_offset - OFS_COUNT;
	assign st_hit  = (reg_offset >= OFS_STATUS) && (st_rel < OFS_W'(CHANNELS))
		&& (st_rel < OFS_W'(2));
	assign cnt_hit = (reg_offset >= OFS_COUNT) && (cnt_rel < OFS_W'(CHANNELS))
		&& (cnt_rel < OFS_W'(2));
	assign st_ch   = st_rel[CW-1:0];
	assign cnt_ch  = cnt_rel[CW-1:0];

	// Next state and result for the word at the input.
	always_comb begin
		count_d  = count_q;
		ovf_d    = ovf_q;
		phase_d  = phase_q;
		status_d = status_q;
		armed_d  = armed_q;
		result   = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			phase_inc[i] = {1'b0, phase_q[i]} + (DIV_W+1)'(1);
		end
		case (mode_e_t'(mode))
			MODE_TICK: begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (phase_inc[i] >= {1'b0, div_eff}) begin
						phase_d[i] = '0;
						count_d[i] = count_q[i] + BYTE_W'(1);
						if (count_q[i] == COUNT_MAX) begin
							ovf_d[i] = 1'b1;
						end
					end else begin
						phase_d[i] = phase_inc[i][DIV_W-1:0];
					end
				end
				// Channel 0 fires once per arming after its counter overflows.
				if (armed_q && ovf_d[0] && !interrupts_masked) begin
					armed_d            = 1'b0;
					result.irq_request = irq_enable_q;
				end
			end
			MODE_READ: begin
				if (st_hit) begin
					result.read_data          = status_q[st_ch];
					result.read_data[OVF_BIT] = status_q[st_ch][OVF_BIT] | ovf_q[st_ch];
					result.handled            = 1'b1;
				end else if (cnt_hit) begin
					result.read_data = count_q[cnt_ch];
					result.handled   = 1'b1;
				end
			end
			MODE_WRITE: begin
				if (cnt_hit) begin
					count_d[cnt_ch] = write_data;
					phase_d[cnt_ch] = '0;
					ovf_d[cnt_ch]   = 1'b0;
					if (cnt_ch == CW'(0)) begin
						armed_d = 1'b1;
					end
					result.handled = 1'b1;
				end else if (st_hit) begin
					// Writing the overflow bit as zero acknowledges a pending overflow.
					if (!write_data[OVF_BIT] && ovf_q[st_ch]) begin
						ovf_d[st_ch]   = 1'b0;
						phase_d[st_ch] = '0;
						if (st_ch == CW'(0)) begin
							armed_d = 1'b1;
						end
					end
					status_d[st_ch]          = write_data;
					status_d[st_ch][OVF_BIT] = 1'b0;
					result.handled           = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// State registers advance only on an accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				count_q[i]  <= '0;
				ovf_q[i]    <= 1'b0;
				phase_q[i]  <= '0;
				status_q[i] <= '0;
			end
			armed_q <= 1'b0;
		end else if (accept) begin
			count_q  <= count_d;
			ovf_q    <= ovf_d;
			phase_q  <= phase_d;
			status_q <= status_d;
			armed_q  <= armed_d;
		end
	end

endmodule

@@ sv/d8ot_out_buf.sv @@
// Two-entry output buffer for result words: a main register and a skid register.
// Depends on d8ot_pkg for the result word type.
module d8ot_out_buf
	import d8ot_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rsp_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);

	logic main_v_q, skid_v_q;
	rsp_t main_q, skid_q;
	logic push, pop;

	assign in_ready  = !skid_v_q;
	assign push      = in_valid && !skid_v_q;
	assign pop       = main_v_q && out_ready;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			if (!main_v_q) begin
				main_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// Word storage; the skid word moves up when the main word leaves.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= in_data;
			end
		end else if (push) begin
			if (!main_v_q) begin
				main_q <= in_data;
			end else begin
				skid_q <= in_data;
			end
		end
	end

endmodule
